### rtl/ctt_pkg.sv
// Package for the command transaction tracker: types, codes and constants.
package ctt_pkg;

  localparam int unsigned RemoteCount = 16;
  localparam int unsigned IdxW = $clog2(RemoteCount);
  localparam int unsigned CountWidth = 32;
  localparam logic [7:0] GetstatDataSize = 8'd11;

  typedef enum logic [2:0] {
    REQ_SEND  = 3'd0,
    REQ_RESP  = 3'd1,
    REQ_TICK  = 3'd2,
    REQ_READ  = 3'd3,
    REQ_CLEAR = 3'd4
  } req_e;

  typedef enum logic [3:0] {
    EV_SENT    = 4'd0,
    EV_BUSY    = 4'd1,
    EV_BAD_ID  = 4'd2,
    EV_ACK     = 4'd3,
    EV_STAT_OK = 4'd4,
    EV_BAD_LEN = 4'd5,
    EV_UNEXP   = 4'd6,
    EV_INVALID = 4'd7,
    EV_BAD_SRC = 4'd8,
    EV_TIMEOUT = 4'd9,
    EV_READ    = 4'd10
  } event_e;

  typedef enum logic [2:0] {
    CFG_TIMEOUT = 3'd0,
    CFG_PING    = 3'd1,
    CFG_MOVE    = 3'd2,
    CFG_STOP    = 3'd3,
    CFG_GETSTAT = 3'd4
  } cfg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_EMIT,
    ST_OUT,
    ST_CLEAR
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic          load;      // capture the input item
    logic          exec;      // perform single-event work, load output
    logic          tick;      // advance time
    logic          scan_chk;  // check entry scan_idx, time it out and mark it
    logic          emit;      // report entry scan_idx if marked
    logic [IdxW-1:0] scan_idx;
    logic          clr;       // clear statistics, entry clr_idx
    logic [IdxW-1:0] clr_idx;
  } ctrl_t;

  // datapath -> controller
  typedef struct packed {
    req_e req;
    logic hit;       // entry scan_idx is marked as timed out
    logic any_later; // some later entry is marked as timed out
  } stat_t;

endpackage

### rtl/ctt_datapath.sv
// Datapath of the tracker: per-remote tables, counters and the output register.
module ctt_datapath import ctt_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i,
  input  ctrl_t               ctrl_i,
  output stat_t               stat_o,
  input  logic [2:0]          req_type_i,
  input  logic [7:0]          rem_id_i,
  input  logic [7:0]          command_i,
  input  logic signed [7:0]   argument_i,
  input  logic                frame_valid_i,
  input  logic [7:0]          pay_len_i,
  input  logic signed [7:0]   stat_move_i,
  input  logic [31:0]         stat_uptime_i,
  input  logic [31:0]         stat_received_i,
  input  logic [7:0]          stat_last_cmd_i,
  input  logic                stat_radio_ok_i,
  input  logic [3:0]          counter_select_i,
  input  logic                out_take_i,
  output logic                out_valid_o,
  output logic [3:0]          event_code_o,
  output logic [7:0]          event_remote_o,
  output logic [31:0]         latency_o,
  output logic                connected_o,
  output logic                waiting_o,
  output logic signed [7:0]   move_val_o,
  output logic [7:0]          last_cmd_o,
  output logic [63:0]         counter_value_o,
  output logic                last_o
);

  localparam int unsigned CntW = CountWidth;

  logic [31:0] timeout_q;
  logic [7:0]  move_q, stop_q, getstat_q;

  logic [2:0]  req_q;
  logic [7:0]  rid_q, cmd_q, arg_q, len_q, smove_q, slast_q;
  logic        fv_q, sradio_q;
  logic [31:0] sup_q, srx_q;
  logic [3:0]  sel_q;

  logic [31:0] time_q;
  logic [RemoteCount-1:0] wait_q, link_q, due_q;
  logic [7:0]  pcmd_q  [RemoteCount];
  logic [7:0]  parg_q  [RemoteCount];
  logic [31:0] pstart_q[RemoteCount];
  logic [7:0]  rmove_q [RemoteCount];
  logic [7:0]  rlast_q [RemoteCount];
  logic [1:0]  flags_q [RemoteCount];
  logic [31:0] rup_q   [RemoteCount];
  logic [31:0] rrx_q   [RemoteCount];
  logic [CntW-1:0] csent_q[RemoteCount];
  logic [CntW-1:0] cack_q [RemoteCount];
  logic [CntW-1:0] ctout_q[RemoteCount];
  logic [CntW-1:0] cunex_q[RemoteCount];
  logic [31:0] cmax_q [RemoteCount];
  logic [63:0] total_q[RemoteCount];
  logic [CntW-1:0] rxv_q, rxi_q, rxs_q;

  logic            id_ok;
  logic [IdxW-1:0] idx;
  logic [7:0]      rid_m1;
  logic            match, is_stat;
  logic [31:0]     lat;
  logic [31:0]     age;
  logic            tout_hit;
  logic            emit_hit;
  logic [RemoteCount-1:0] later;

  assign rid_m1  = rid_q - 8'd1;
  assign id_ok   = (rid_q != 8'd0) && ({24'd0, rid_q} <= RemoteCount);
  assign idx     = rid_m1[IdxW-1:0];
  assign is_stat = (cmd_q == getstat_q);
  assign match   = wait_q[idx] && (cmd_q == pcmd_q[idx]) && (is_stat || arg_q == parg_q[idx]);
  assign lat     = time_q - pstart_q[idx];
  assign age     = time_q - pstart_q[ctrl_i.scan_idx];
  assign tout_hit = wait_q[ctrl_i.scan_idx] && (age >= timeout_q);
  assign emit_hit = ctrl_i.emit && due_q[ctrl_i.scan_idx];

  // timed-out entries above the current report position
  always_comb begin
    for (int k = 0; k < RemoteCount; k++) begin
      later[k] = due_q[k] && (k > int'(ctrl_i.scan_idx));
    end
  end

  assign stat_o.req       = req_e'(req_q);
  assign stat_o.hit       = due_q[ctrl_i.scan_idx];
  assign stat_o.any_later = |later;

  function automatic logic [CntW-1:0] inc(input logic [CntW-1:0] v);
    return v + CntW'(1);
  endfunction

  logic [63:0] rd_val;
  always_comb begin
    case (sel_q)
      4'd0:  rd_val = 64'(csent_q[idx]);
      4'd1:  rd_val = 64'(cack_q[idx]);
      4'd2:  rd_val = 64'(ctout_q[idx]);
      4'd3:  rd_val = 64'(cunex_q[idx]);
      4'd4:  rd_val = total_q[idx];
      4'd5:  rd_val = 64'(cmax_q[idx]);
      4'd6:  rd_val = 64'(rup_q[idx]);
      4'd7:  rd_val = 64'(rrx_q[idx]);
      4'd8:  rd_val = 64'(rxv_q);
      4'd9:  rd_val = 64'(rxi_q);
      4'd10: rd_val = 64'(rxs_q);
      4'd11: rd_val = {60'd0, wait_q[idx], link_q[idx], flags_q[idx]};
      default: rd_val = 64'd0;
    endcase
  end

  // the ping code names a command only; nothing depends on it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= 32'd150000;
      move_q    <= 8'd2;
      stop_q    <= 8'd3;
      getstat_q <= 8'd4;
    end else if (cfg_we_i) begin
      case (cfg_e'(cfg_index_i))
        CFG_TIMEOUT: timeout_q <= cfg_data_i;
        CFG_PING:    ;
        CFG_MOVE:    move_q    <= cfg_data_i[7:0];
        CFG_STOP:    stop_q    <= cfg_data_i[7:0];
        CFG_GETSTAT: getstat_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      req_q <= req_type_i;   rid_q <= rem_id_i;     cmd_q <= command_i;
      arg_q <= argument_i;   fv_q <= frame_valid_i; len_q <= pay_len_i;
      smove_q <= stat_move_i; sup_q <= stat_uptime_i; srx_q <= stat_received_i;
      slast_q <= stat_last_cmd_i; sradio_q <= stat_radio_ok_i;
      sel_q <= counter_select_i;
    end
  end

  // state tables
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q <= '0; wait_q <= '0; link_q <= '0; due_q <= '0;
      rxv_q <= '0; rxi_q <= '0; rxs_q <= '0;
      for (int k = 0; k < RemoteCount; k++) begin
        pcmd_q[k] <= '0; parg_q[k] <= '0; pstart_q[k] <= '0;
        rmove_q[k] <= '0; rlast_q[k] <= '0; flags_q[k] <= '0;
        rup_q[k] <= '0; rrx_q[k] <= '0; csent_q[k] <= '0; cack_q[k] <= '0;
        ctout_q[k] <= '0; cunex_q[k] <= '0; cmax_q[k] <= '0; total_q[k] <= '0;
      end
    end else begin
      if (ctrl_i.tick) time_q <= time_q + 32'd1;
      if (ctrl_i.clr) begin
        csent_q[ctrl_i.clr_idx] <= '0; cack_q[ctrl_i.clr_idx] <= '0;
        ctout_q[ctrl_i.clr_idx] <= '0; cunex_q[ctrl_i.clr_idx] <= '0;
        cmax_q[ctrl_i.clr_idx] <= '0;  total_q[ctrl_i.clr_idx] <= '0;
        rxv_q <= '0; rxi_q <= '0; rxs_q <= '0;
      end
      if (ctrl_i.scan_chk) begin
        due_q[ctrl_i.scan_idx] <= tout_hit;
        if (tout_hit) begin
          ctout_q[ctrl_i.scan_idx] <= inc(ctout_q[ctrl_i.scan_idx]);
          link_q[ctrl_i.scan_idx]  <= 1'b0;
          wait_q[ctrl_i.scan_idx]  <= 1'b0;
        end
      end
      if (ctrl_i.exec) begin
        case (req_e'(req_q))
          REQ_SEND: if (id_ok && !wait_q[idx]) begin
            pcmd_q[idx] <= cmd_q; parg_q[idx] <= arg_q; pstart_q[idx] <= time_q;
            wait_q[idx] <= 1'b1; csent_q[idx] <= inc(csent_q[idx]);
          end
          REQ_RESP: begin
            if (!fv_q) rxi_q <= inc(rxi_q);
            else begin
              rxv_q <= inc(rxv_q);
              if (!id_ok) rxs_q <= inc(rxs_q);
              else if (!match) cunex_q[idx] <= inc(cunex_q[idx]);
              else begin
                total_q[idx] <= total_q[idx] + 64'(lat);
                if (lat > cmax_q[idx]) cmax_q[idx] <= lat;
                cack_q[idx] <= inc(cack_q[idx]);
                link_q[idx] <= 1'b1; wait_q[idx] <= 1'b0;
                if (is_stat) begin
                  if (len_q == GetstatDataSize) begin
                    rmove_q[idx] <= smove_q; rup_q[idx] <= sup_q;
                    rrx_q[idx] <= srx_q; rlast_q[idx] <= slast_q;
                    flags_q[idx] <= {sradio_q, 1'b1};
                  end
                end else begin
                  rlast_q[idx] <= cmd_q;
                  if (cmd_q == move_q) rmove_q[idx] <= arg_q;
                  else if (cmd_q == stop_q) rmove_q[idx] <= 8'd0;
                end
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  // output register; remote fields are sampled from the state after the event,
  // so they are filled in when the event's update has landed (when fill_q is set)
  logic fill_q;
  logic [IdxW-1:0] oidx_q;
  logic            ook_q;
  logic [3:0]  ev_d;
  logic [31:0] lat_d;
  logic [63:0] cnt_d;

  always_comb begin
    ev_d = EV_READ; lat_d = '0; cnt_d = '0;
    case (req_e'(req_q))
      REQ_SEND: ev_d = !id_ok ? EV_BAD_ID : wait_q[idx] ? EV_BUSY : EV_SENT;
      REQ_RESP: begin
        if (!fv_q) ev_d = EV_INVALID;
        else if (!id_ok) ev_d = EV_BAD_SRC;
        else if (!match) ev_d = EV_UNEXP;
        else begin
          lat_d = lat;
          ev_d = !is_stat ? EV_ACK : (len_q == GetstatDataSize) ? EV_STAT_OK : EV_BAD_LEN;
        end
      end
      default: begin
        ev_d = id_ok ? EV_READ : EV_BAD_ID;
        cnt_d = id_ok ? rd_val : 64'd0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
      fill_q <= 1'b0;
    end else begin
      fill_q <= ctrl_i.exec || emit_hit;
      if (fill_q) out_valid_o <= 1'b1;
      else if (out_take_i) out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.exec) begin
      event_code_o <= ev_d; event_remote_o <= rid_q; latency_o <= lat_d;
      counter_value_o <= cnt_d; last_o <= 1'b1;
      oidx_q <= idx; ook_q <= id_ok;
    end else if (emit_hit) begin
      event_code_o <= EV_TIMEOUT;
      event_remote_o <= 8'(ctrl_i.scan_idx) + 8'd1;
      latency_o <= '0; counter_value_o <= '0;
      last_o <= !(|later);
      oidx_q <= ctrl_i.scan_idx; ook_q <= 1'b1;
    end
    if (fill_q) begin
      connected_o    <= ook_q & link_q[oidx_q];
      waiting_o      <= ook_q & wait_q[oidx_q];
      move_val_o     <= ook_q ? rmove_q[oidx_q] : 8'd0;
      last_cmd_o     <= ook_q ? rlast_q[oidx_q] : 8'd0;
    end
  end

endmodule

### rtl/ctt_ctrl.sv
// Controller state machine of the tracker: sequences each item through the datapath.
module ctt_ctrl import ctt_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  input  logic  out_busy_i,
  input  stat_t stat_i,
  output ctrl_t ctrl_o
);

  state_e state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [1:0] wait_q, wait_d;
  logic       fin_q, fin_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; idx_q <= '0; wait_q <= '0; fin_q <= 1'b0;
    end else begin
      state_q <= state_d; idx_q <= idx_d; wait_q <= wait_d; fin_q <= fin_d;
    end
  end

  // SCAN times out and marks entries, EMIT reports the marked ones in ID order
  // OUT waits for the output fill, then for the slot to drain
  always_comb begin
    state_d = state_q; idx_d = idx_q; wait_d = wait_q; fin_d = fin_q;
    ctrl_o = '0;
    ctrl_o.scan_idx = idx_q;
    ctrl_o.clr_idx  = idx_q;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          ctrl_o.load = 1'b1;
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        idx_d = '0;
        case (stat_i.req)
          REQ_SEND, REQ_RESP, REQ_READ: begin
            ctrl_o.exec = 1'b1; fin_d = 1'b1; wait_d = '0; state_d = ST_OUT;
          end
          REQ_TICK: begin
            ctrl_o.tick = 1'b1; state_d = ST_SCAN;
          end
          REQ_CLEAR: state_d = ST_CLEAR;
          default: state_d = ST_IDLE;
        endcase
      end
      ST_SCAN: begin
        ctrl_o.scan_chk = 1'b1;
        idx_d = idx_q + IdxW'(1);
        if (idx_q == IdxW'(RemoteCount - 1)) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_busy_i) begin
          ctrl_o.emit = 1'b1;
          idx_d = idx_q + IdxW'(1);
          if (stat_i.hit) begin
            fin_d = !stat_i.any_later;
            wait_d = '0; state_d = ST_OUT;
          end else if (!stat_i.any_later) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_OUT: begin
        if (wait_q != 2'd2) wait_d = wait_q + 2'd1;
        else if (!out_busy_i) state_d = fin_q ? ST_IDLE : ST_EMIT;
      end
      ST_CLEAR: begin
        ctrl_o.clr = 1'b1;
        idx_d = idx_q + IdxW'(1);
        if (idx_q == IdxW'(RemoteCount - 1)) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

### rtl/command_transaction_tracker_core.sv
// Top level of the command transaction tracker: controller plus datapath.
// One item is handled at a time. A tick first checks all sixteen entries,
// one per cycle, then walks the timed-out ones in ID order, reporting each
// and stepping through the entries up to the last timed-out remote; the
// walk waits while the output is busy. A statistics clear resets the
// counters of each remote in turn. A result stays on the output until
// taken; the next item is accepted once the last result is delivered.
module command_transaction_tracker_core import ctt_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [2:0]          req_type_i,
  input  logic [7:0]          rem_id_i,
  input  logic [7:0]          command_i,
  input  logic signed [7:0]   argument_i,
  input  logic                frame_valid_i,
  input  logic [7:0]          pay_len_i,
  input  logic signed [7:0]   stat_move_i,
  input  logic [31:0]         stat_uptime_i,
  input  logic [31:0]         stat_received_i,
  input  logic [7:0]          stat_last_cmd_i,
  input  logic                stat_radio_ok_i,
  input  logic [3:0]          counter_select_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [3:0]          event_code_o,
  output logic [7:0]          event_remote_o,
  output logic [31:0]         latency_o,
  output logic                connected_o,
  output logic                waiting_o,
  output logic signed [7:0]   move_val_o,
  output logic [7:0]          last_cmd_o,
  output logic [63:0]         counter_value_o,
  output logic                last_o
);

  ctrl_t ctrl;
  stat_t stat;
  logic  take;

  assign take = out_valid_o & ~out_stall_i;

  ctt_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .out_busy_i(out_valid_o & ~take),
    .stat_i(stat), .ctrl_o(ctrl)
  );

  ctt_datapath u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .ctrl_i(ctrl), .stat_o(stat),
    .req_type_i, .rem_id_i, .command_i, .argument_i, .frame_valid_i,
    .pay_len_i, .stat_move_i, .stat_uptime_i, .stat_received_i,
    .stat_last_cmd_i, .stat_radio_ok_i, .counter_select_i,
    .out_take_i(take), .out_valid_o,
    .event_code_o, .event_remote_o, .latency_o, .connected_o, .waiting_o,
    .move_val_o, .last_cmd_o, .counter_value_o, .last_o
  );

endmodule
